>>> design/w2s_pkg.sv
// ----------------------------------------------------------------------------
// w2s_pkg
// Shared constants and types of the world-to-screen projection unit.
// ----------------------------------------------------------------------------
package w2s_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int SIZE_W    = 16;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int ROW_W     = PROD_W - FRAC_BITS + 2;
	localparam int NUM_W     = ROW_W + SIZE_W;
	localparam int REM_W     = ROW_W + 1;
	localparam int QUOT_W    = 41;
	localparam int SUM_W     = 64;

	localparam logic [CFG_IDX_W-1:0] REG_ROW0_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_A = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_B = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd7;

	localparam logic signed [ROW_W-1:0] VIS_THRESH =
		ROW_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [QUOT_W-1:0] QUOT_CAP = {1'b1, {(QUOT_W-1){1'b0}}};

	typedef struct packed {
		logic              valid;
		logic              vis;
		logic              neg_x;
		logic              neg_y;
		logic [NUM_W-1:0]  num_x;
		logic [NUM_W-1:0]  num_y;
		logic [ROW_W-1:0]  den;
	} div_in_t;

	typedef struct packed {
		logic              valid;
		logic              vis;
		logic              neg_x;
		logic              neg_y;
		logic              sat_x;
		logic              sat_y;
		logic [QUOT_W-1:0] q_x;
		logic [QUOT_W-1:0] q_y;
	} div_out_t;

	typedef struct packed {
		logic              valid;
		logic              vis;
		logic              neg_x;
		logic              neg_y;
		logic              sat_x;
		logic              sat_y;
		logic [REM_W-1:0]  rem_x;
		logic [REM_W-1:0]  rem_y;
		logic [QUOT_W-1:0] low_x;
		logic [QUOT_W-1:0] low_y;
		logic [QUOT_W-1:0] q_x;
		logic [QUOT_W-1:0] q_y;
		logic [ROW_W-1:0]  den;
	} div_stage_t;

endpackage

>>> design/w2s_div.sv
// ----------------------------------------------------------------------------
// w2s_div
// Pipelined restoring divider for both screen axes, one quotient bit a stage.
// ----------------------------------------------------------------------------
module w2s_div (
	input  logic               clk,
	input  logic               arst_n,
	input  w2s_pkg::div_in_t   din,
	output w2s_pkg::div_out_t  dout
);
	import w2s_pkg::*;

	div_stage_t stage_s [QUOT_W+1];
	div_stage_t first_c;

	always_comb begin
		first_c       = '0;
		first_c.valid = din.valid;
		first_c.vis   = din.vis;
		first_c.neg_x = din.neg_x;
		first_c.neg_y = din.neg_y;
		first_c.den   = din.den;
		first_c.rem_x = {{(REM_W-(NUM_W-QUOT_W)){1'b0}}, din.num_x[NUM_W-1:QUOT_W]};
		first_c.rem_y = {{(REM_W-(NUM_W-QUOT_W)){1'b0}}, din.num_y[NUM_W-1:QUOT_W]};
		first_c.low_x = din.num_x[QUOT_W-1:0];
		first_c.low_y = din.num_y[QUOT_W-1:0];
		first_c.sat_x = first_c.rem_x >= {1'b0, din.den};
		first_c.sat_y = first_c.rem_y >= {1'b0, din.den};
		first_c.q_x   = '0;
		first_c.q_y   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s[0] <= '0;
		end else begin
			stage_s[0] <= first_c;
		end
	end

	for (genvar k = 0; k < QUOT_W; k++) begin : g_step
		logic [REM_W-1:0] try_x;
		logic [REM_W-1:0] try_y;
		logic             ge_x;
		logic             ge_y;
		div_stage_t       nxt;

		always_comb begin
			try_x = {stage_s[k].rem_x[REM_W-2:0], stage_s[k].low_x[QUOT_W-1-k]};
			try_y = {stage_s[k].rem_y[REM_W-2:0], stage_s[k].low_y[QUOT_W-1-k]};
			ge_x  = try_x >= {1'b0, stage_s[k].den};
			ge_y  = try_y >= {1'b0, stage_s[k].den};
			nxt       = stage_s[k];
			nxt.rem_x = ge_x ? try_x - {1'b0, stage_s[k].den} : try_x;
			nxt.rem_y = ge_y ? try_y - {1'b0, stage_s[k].den} : try_y;
			nxt.q_x   = {stage_s[k].q_x[QUOT_W-2:0], ge_x};
			nxt.q_y   = {stage_s[k].q_y[QUOT_W-2:0], ge_y};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_s[k+1] <= '0;
			end else begin
				stage_s[k+1] <= nxt;
			end
		end
	end

	always_comb begin
		dout.valid = stage_s[QUOT_W].valid;
		dout.vis   = stage_s[QUOT_W].vis;
		dout.neg_x = stage_s[QUOT_W].neg_x;
		dout.neg_y = stage_s[QUOT_W].neg_y;
		dout.sat_x = stage_s[QUOT_W].sat_x;
		dout.sat_y = stage_s[QUOT_W].sat_y;
		dout.q_x   = stage_s[QUOT_W].q_x;
		dout.q_y   = stage_s[QUOT_W].q_y;
	end

endmodule

>>> design/world_to_screen_projection_unit.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit
// Projects a Q16.16 world point through a view matrix onto screen coordinates.
// ----------------------------------------------------------------------------
// Channel  | Ports                                  | Handshake
// input    | point_x, point_y, point_z              | start high, busy low
// result   | visible, screen_x, screen_y            | done high for one cycle
// config   | cfg_we, cfg_index, cfg_data            | written when cfg_we high
//
// One item may enter in every cycle; busy is always low.
// Each item passes through the matrix products, row sums and scaling stages,
// then through the one-bit-a-stage divider and the registered result outputs.
// Reset clears the pipeline valid bits and loads the default registers.
// Results cannot be held off, so nothing in the pipeline ever stalls.
// ----------------------------------------------------------------------------
module world_to_screen_projection_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [w2s_pkg::COORD_W-1:0]    point_x,
	input  logic signed [w2s_pkg::COORD_W-1:0]    point_y,
	input  logic signed [w2s_pkg::COORD_W-1:0]    point_z,
	output logic                                  done,
	output logic                                  visible,
	output logic signed [w2s_pkg::COORD_W-1:0]    screen_x,
	output logic signed [w2s_pkg::COORD_W-1:0]    screen_y,
	input  logic                                  cfg_we,
	input  logic [w2s_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [w2s_pkg::CFG_W-1:0]             cfg_data
);
	import w2s_pkg::*;

	logic [CFG_W-1:0]  row0a_q, row0b_q, row1a_q, row1b_q, row3a_q, row3b_q;
	logic [SIZE_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0a_q  <= '0;
			row0b_q  <= '0;
			row1a_q  <= '0;
			row1b_q  <= '0;
			row3a_q  <= '0;
			row3b_q  <= '0;
			width_q  <= SIZE_W'(1920);
			height_q <= SIZE_W'(1080);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW0_A: row0a_q  <= cfg_data;
				REG_ROW0_B: row0b_q  <= cfg_data;
				REG_ROW1_A: row1a_q  <= cfg_data;
				REG_ROW1_B: row1b_q  <= cfg_data;
				REG_ROW3_A: row3a_q  <= cfg_data;
				REG_ROW3_B: row3b_q  <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				default:    ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Stage 1: the nine coefficient products.
	logic                     valid_s1;
	logic signed [PROD_W-1:0] px0_s1, px1_s1, px2_s1;
	logic signed [PROD_W-1:0] py0_s1, py1_s1, py2_s1;
	logic signed [PROD_W-1:0] pw0_s1, pw1_s1, pw2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		px0_s1 <= $signed(row0a_q[31:0])  * point_x;
		px1_s1 <= $signed(row0a_q[63:32]) * point_y;
		px2_s1 <= $signed(row0b_q[31:0])  * point_z;
		py0_s1 <= $signed(row1a_q[31:0])  * point_x;
		py1_s1 <= $signed(row1a_q[63:32]) * point_y;
		py2_s1 <= $signed(row1b_q[31:0])  * point_z;
		pw0_s1 <= $signed(row3a_q[31:0])  * point_x;
		pw1_s1 <= $signed(row3a_q[63:32]) * point_y;
		pw2_s1 <= $signed(row3b_q[31:0])  * point_z;
	end

	// Stage 2: row sums with each product floored to the coordinate format.
	function automatic logic signed [ROW_W-1:0] row_sum(
		input logic signed [PROD_W-1:0] a,
		input logic signed [PROD_W-1:0] b,
		input logic signed [PROD_W-1:0] c,
		input logic [COORD_W-1:0]       offs
	);
		logic signed [PROD_W-1:0] sa, sb, sc;
		sa = a >>> FRAC_BITS;
		sb = b >>> FRAC_BITS;
		sc = c >>> FRAC_BITS;
		return $signed(sa[ROW_W-1:0]) + $signed(sb[ROW_W-1:0]) + $signed(sc[ROW_W-1:0])
			+ $signed({{(ROW_W-COORD_W){offs[COORD_W-1]}}, offs});
	endfunction

	logic                    valid_s2;
	logic signed [ROW_W-1:0] rx_s2, ry_s2, w_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		rx_s2 <= row_sum(px0_s1, px1_s1, px2_s1, row0b_q[63:32]);
		ry_s2 <= row_sum(py0_s1, py1_s1, py2_s1, row1b_q[63:32]);
		w_s2  <= row_sum(pw0_s1, pw1_s1, pw2_s1, row3b_q[63:32]);
	end

	// Stage 3: visibility, magnitudes scaled by the screen size, divisor 2w.
	logic [ROW_W-1:0] abs_x, abs_y;
	div_in_t          div_s3;

	assign abs_x = rx_s2[ROW_W-1] ? ROW_W'(-rx_s2) : ROW_W'(rx_s2);
	assign abs_y = ry_s2[ROW_W-1] ? ROW_W'(-ry_s2) : ROW_W'(ry_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s3 <= '0;
		end else begin
			div_s3.valid <= valid_s2;
			div_s3.vis   <= w_s2 > VIS_THRESH;
			div_s3.neg_x <= rx_s2[ROW_W-1];
			div_s3.neg_y <= ry_s2[ROW_W-1];
			div_s3.num_x <= NUM_W'(abs_x) * NUM_W'(width_q);
			div_s3.num_y <= NUM_W'(abs_y) * NUM_W'(height_q);
			div_s3.den   <= {w_s2[ROW_W-2:0], 1'b0};
		end
	end

	div_out_t div_out;

	w2s_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (div_s3),
		.dout   (div_out)
	);

	// Final stage: cap, sign, centre offset and saturation.
	function automatic logic signed [COORD_W-1:0] sat_coord(
		input logic signed [SUM_W-1:0] v
	);
		logic signed [SUM_W-1:0] hi, lo;
		hi = SUM_W'(64'sd2147483647);
		lo = -SUM_W'(64'sd2147483648);
		if (v > hi) begin
			return COORD_W'(hi);
		end else if (v < lo) begin
			return COORD_W'(lo);
		end
		return v[COORD_W-1:0];
	endfunction

	logic [QUOT_W-1:0]       qcap_x, qcap_y;
	logic signed [SUM_W-1:0] sq_x, sq_y, half_x, half_y, sum_x, sum_y;

	always_comb begin
		qcap_x = (div_out.sat_x || div_out.q_x[QUOT_W-1]) ? QUOT_CAP : div_out.q_x;
		qcap_y = (div_out.sat_y || div_out.q_y[QUOT_W-1]) ? QUOT_CAP : div_out.q_y;
		sq_x   = div_out.neg_x ? -$signed(SUM_W'(qcap_x)) : $signed(SUM_W'(qcap_x));
		sq_y   = div_out.neg_y ? -$signed(SUM_W'(qcap_y)) : $signed(SUM_W'(qcap_y));
		half_x = $signed(SUM_W'(width_q) << (FRAC_BITS - 1));
		half_y = $signed(SUM_W'(height_q) << (FRAC_BITS - 1));
		sum_x  = half_x + sq_x;
		sum_y  = half_y - sq_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		visible  <= div_out.vis;
		screen_x <= div_out.vis ? sat_coord(sum_x) : '0;
		screen_y <= div_out.vis ? sat_coord(sum_y) : '0;
	end

endmodule

>>> verif/world_to_screen_projection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection_checker
// Watches the configuration, item and result channels of the projection unit.
// It keeps its own copy of the matrix rows and the screen size, predicts the
// screen position of every accepted item, and compares each result in order.
// ----------------------------------------------------------------------------
module world_to_screen_projection_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic signed [w2s_pkg::COORD_W-1:0] point_x,
	input  logic signed [w2s_pkg::COORD_W-1:0] point_y,
	input  logic signed [w2s_pkg::COORD_W-1:0] point_z,
	input  logic                               done,
	input  logic                               visible,
	input  logic signed [w2s_pkg::COORD_W-1:0] screen_x,
	input  logic signed [w2s_pkg::COORD_W-1:0] screen_y,
	input  logic                               cfg_we,
	input  logic [w2s_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [w2s_pkg::CFG_W-1:0]          cfg_data,
	output int                                 mismatches,
	output int                                 pending
);
	import w2s_pkg::*;

	typedef struct packed {
		logic        vis;
		logic [31:0] sx;
		logic [31:0] sy;
	} screen_pos_t;

	logic signed [31:0] coef [3][4];
	logic [15:0]        width_px;
	logic [15:0]        height_px;
	screen_pos_t        positions_due [$];

	function automatic logic signed [79:0] row_value(input int r, input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz);
		logic signed [79:0] acc;
		logic signed [63:0] a, b, prod;
		logic signed [31:0] pt [3];
		pt[0] = px;
		pt[1] = py;
		pt[2] = pz;
		acc = coef[r][3];
		for (int k = 0; k < 3; k++) begin
			a = coef[r][k];
			b = pt[k];
			prod = a * b;
			acc = acc + (prod >>> FRAC_BITS);
		end
		return acc;
	endfunction

	function automatic logic signed [127:0] scaled_offset(input logic signed [79:0] num,
			input logic [15:0] size, input logic signed [79:0] w);
		logic [127:0] mag, q;
		mag = num < 0 ? 128'(-num) : 128'(num);
		q = (mag * 128'(size)) / (128'(w) * 128'd2);
		if (q > (128'd1 << 40))
			q = 128'd1 << 40;
		return num < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic [31:0] clamp32(input logic signed [127:0] v);
		if (v > 128'sd2147483647)
			return 32'h7fff_ffff;
		if (v < -128'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic screen_pos_t project_point(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz);
		screen_pos_t        res;
		logic signed [79:0] w, rx, ry;
		logic signed [127:0] half_w, half_h;
		w = row_value(2, px, py, pz);
		res = '0;
		if (w <= 80'sd655)
			return res;
		rx = row_value(0, px, py, pz);
		ry = row_value(1, px, py, pz);
		half_w = $signed(128'(width_px) << (FRAC_BITS - 1));
		half_h = $signed(128'(height_px) << (FRAC_BITS - 1));
		res.vis = 1'b1;
		res.sx = clamp32(half_w + scaled_offset(rx, width_px, w));
		res.sy = clamp32(half_h - scaled_offset(ry, height_px, w));
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		screen_pos_t want;
		if (!arst_n) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 4; c++)
					coef[r][c] = '0;
			width_px = 16'd1920;
			height_px = 16'd1080;
			positions_due.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (positions_due.size() == 0) begin
					report_mismatch("unexpected result", screen_x, '0);
				end else begin
					want = positions_due.pop_front();
					if (visible !== want.vis)
						report_mismatch("visible", 32'(visible), 32'(want.vis));
					if (screen_x !== want.sx)
						report_mismatch("screen_x", screen_x, want.sx);
					if (screen_y !== want.sy)
						report_mismatch("screen_y", screen_y, want.sy);
				end
			end
			if (start && !busy)
				positions_due.push_back(project_point(point_x, point_y, point_z));
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH: width_px = cfg_data[15:0];
					REG_HEIGHT: height_px = cfg_data[15:0];
					default: begin
						coef[cfg_index >> 1][(cfg_index & 1) * 2] = cfg_data[31:0];
						coef[cfg_index >> 1][(cfg_index & 1) * 2 + 1] = cfg_data[63:32];
					end
				endcase
			end
			pending = positions_due.size();
		end
	end

endmodule

>>> verif/world_to_screen_projection_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit_tb
// Drives the projection unit through several view matrices and screen sizes,
// including the extremes, with directed and random points sent in bursts.
// The checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module world_to_screen_projection_unit_tb;
	import w2s_pkg::*;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic signed [COORD_W-1:0] point_x, point_y, point_z;
	logic                     done;
	logic                     visible;
	logic signed [COORD_W-1:0] screen_x, screen_y;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]         cfg_data;
	int                       mismatches;
	int                       pending;
	int                       cycles;

	world_to_screen_projection_unit i_dut (.*);

	world_to_screen_projection_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 | $urandom_range(0, 3);
			1: return 32'h7fff_ffff - $urandom_range(0, 3);
			2: return 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
			3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			4: return 32'($signed($urandom_range(0, 200)) - 100) <<< $urandom_range(10, 20);
			default: return $urandom();
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		int gap;
		@(negedge clk);
		start <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		do @(posedge clk); while (busy);
		gap = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 6);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// A view: scales sx and sy on x and y, w taken mainly from z plus an offset, small random cross terms.
	task automatic load_view(input logic [31:0] sx, input logic [31:0] sy,
			input logic [31:0] wz, input logic [31:0] woff, input logic [15:0] wd,
			input logic [15:0] ht);
		write_reg(REG_ROW0_A, {32'($urandom_range(0, 8000)) - 32'd4000, sx});
		write_reg(REG_ROW0_B, {32'($urandom()), 32'($urandom_range(0, 8000)) - 32'd4000});
		write_reg(REG_ROW1_A, {sy, 32'($urandom_range(0, 8000)) - 32'd4000});
		write_reg(REG_ROW1_B, {32'($urandom()), 32'($urandom_range(0, 8000)) - 32'd4000});
		write_reg(REG_ROW3_A, {32'($urandom_range(0, 2000)) - 32'd1000,
			32'($urandom_range(0, 2000)) - 32'd1000});
		write_reg(REG_ROW3_B, {woff, wz});
		write_reg(REG_WIDTH, {48'($urandom()), wd});
		write_reg(REG_HEIGHT, {48'($urandom()), ht});
	endtask

	initial begin
		logic [31:0] z;
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset matrix gives w of zero, so nothing is visible.
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
		drain();

		load_view(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd0, 16'd1920, 16'd1080);
		send_point(32'h0001_0000, 32'h0001_0000, 32'd655);
		send_point(32'h0001_0000, 32'h0001_0000, 32'd656);
		send_point(32'h0001_0000, 32'hffff_0000, 32'd656);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'd700);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		send_point(32'h0002_0000, 32'hfffe_0000, 32'h0004_0000);
		send_point(32'h0, 32'h0, 32'h0001_0000);
		send_point(32'h0001_0000, 32'h0001_0000, 32'hffff_0000);
		send_point(32'hffff_ffff, 32'hffff_ffff, 32'h0000_1000);
		drain();

		load_view(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 16'd0, 16'd0);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		send_point(32'h0001_0000, 32'h0001_0000, 32'h0);
		drain();

		load_view(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 32'd1000, 16'd65535, 16'd1);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'd1);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h0010_0000);
		send_point(32'h0000_8000, 32'hffff_8000, 32'h0000_0001);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 5) begin
				for (int r = 0; r < 6; r++)
					write_reg(r[CFG_IDX_W-1:0], {$urandom(), $urandom()});
				write_reg(REG_WIDTH, 64'($urandom()));
				write_reg(REG_HEIGHT, 64'($urandom()));
			end else begin
				load_view(pick_value(), pick_value(), 32'h0001_0000 << $urandom_range(0, 3),
					32'($urandom_range(0, 1 << 20)),
					phase == 1 ? 16'd65535 : 16'($urandom_range(1, 4000)),
					phase == 2 ? 16'd1 : 16'($urandom_range(1, 4000)));
			end
			for (int n = 0; n < 275; n++) begin
				if ($urandom_range(0, 9) < 8)
					z = 32'($urandom_range(1, 32'h00ff_ffff));
				else
					z = pick_value();
				send_point(pick_value(), pick_value(), z);
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
